@@ rtl/ghp_pkg.sv @@
package ghp_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int CFG_RESET_DIM  = 512;
    localparam int DIM_W          = 10;
    localparam int CFG_IDX_W      = 8;
    localparam int PIX_W          = 8;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] result_pixel;
        logic             last_of_frame;
    } t_out_item;

    typedef enum logic {
        OP_COLUMN,
        OP_CLEAR
    } t_op_kind;

    typedef struct packed {
        t_op_kind         kind;
        logic             first_col;
        logic             edge_emit;
        logic             col_step;
        logic             top_en;
        logic             mid_en;
        logic             wr_en;
        logic             col_emit;
        logic             last;
        logic [PIX_W-1:0] pixel;
    } t_op;

endpackage

@@ rtl/gaussian_highpass_3x3.sv @@
// Streaming 3x3 Gaussian high-pass for 8-bit raster frames: each result is the pixel
// minus its 1-2-1 weighted neighborhood sum over 16 (zero padding, truncation), modulo
// 256. One request is taken per clock while the queue has room and the output is not
// stalled; the limit is the single read and write port of each line store, touched
// once per request. Results are registered and trail the input by one row plus one
// pixel, so after the last pixel of a frame send image_width + 1 drain requests;
// last_of_frame marks the final result. Line stores come up unwritten and need no
// clearing pass: rows are masked by the row count. Write configuration only while no
// frame is in flight; any write restarts the frame.
module gaussian_highpass_3x3 #(
    parameter int MAX_WIDTH  = ghp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ghp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ghp_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ghp_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ghp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ghp_pkg::DIM_W-1:0]     i_cfg_data
);
    import ghp_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int Q_W      = $bits(t_op) + COL_BITS;

    logic                w_in_accept;
    logic                w_cfg_we;
    logic                w_push;
    t_op                 w_push_op;
    logic [COL_BITS-1:0] w_push_addr;
    logic                w_q_full;
    logic                w_head_valid;
    logic [Q_W-1:0]      w_q_rdata;
    t_op                 w_head_op;
    logic [COL_BITS-1:0] w_head_addr;
    logic                w_pop;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = w_q_full;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_head_op   = t_op'(w_q_rdata[Q_W-1 -: $bits(t_op)]);
    assign w_head_addr = w_q_rdata[COL_BITS-1:0];

    ghp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_BITS   (COL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_in_accept),
        .i_item      (i_in_item),
        .o_push      (w_push),
        .o_op        (w_push_op),
        .o_addr      (w_push_addr)
    );

    ghp_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_op, w_push_addr}),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_data  (w_q_rdata)
    );

    ghp_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_BITS  (COL_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (w_cfg_we),
        .i_head_valid (w_head_valid),
        .i_head_op    (w_head_op),
        .i_head_addr  (w_head_addr),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .i_out_stall  (i_out_stall)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("request classified while the queue is full");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("back end popped an empty queue");

    a_out_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && $past(!o_out_valid) && !w_head_valid && $past(!w_head_valid)
         && $past(!w_head_valid, 2)) |=> !o_out_valid)
        else $error("result appeared without a queued operation");

endmodule

@@ rtl/ghp_front.sv @@
module ghp_front #(
    parameter int MAX_WIDTH  = ghp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ghp_pkg::DEF_MAX_HEIGHT,
    parameter int COL_BITS   = $clog2(MAX_WIDTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ghp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ghp_pkg::DIM_W-1:0]    i_cfg_data,
    input  logic                         i_accept,
    input  ghp_pkg::t_in_item            i_item,
    output logic                         o_push,
    output ghp_pkg::t_op                 o_op,
    output logic [COL_BITS-1:0]          o_addr
);
    import ghp_pkg::*;

    localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS   = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT + 3);
    localparam logic [W_BITS-1:0] RST_W =
        W_BITS'((MAX_WIDTH < CFG_RESET_DIM) ? MAX_WIDTH : CFG_RESET_DIM);
    localparam logic [H_BITS-1:0] RST_H =
        H_BITS'((MAX_HEIGHT < CFG_RESET_DIM) ? MAX_HEIGHT : CFG_RESET_DIM);

    logic [W_BITS-1:0]   r_w, n_w;
    logic [H_BITS-1:0]   r_h, n_h;
    logic [COL_BITS-1:0] r_col, n_col;
    logic [ROW_BITS-1:0] r_row, n_row;

    logic [W_BITS-1:0]   w_cfg_w;
    logic [H_BITS-1:0]   w_cfg_h;
    logic [W_BITS-1:0]   w_col_ext;
    logic [W_BITS-1:0]   w_col_inc;
    logic [ROW_BITS-1:0] w_h_ext;
    logic [ROW_BITS-1:0] w_h_p1;
    logic                w_row_ge_h;
    logic                w_ignore;
    logic                w_abort;
    logic                w_first;
    logic                w_edge;
    logic                w_col_step;
    logic                w_last;

    assign w_cfg_w = (i_cfg_data == '0) ? W_BITS'(1) :
                     ({22'd0, i_cfg_data} > 32'(MAX_WIDTH)) ? W_BITS'(MAX_WIDTH) :
                     W_BITS'(i_cfg_data);
    assign w_cfg_h = (i_cfg_data == '0) ? H_BITS'(1) :
                     ({22'd0, i_cfg_data} > 32'(MAX_HEIGHT)) ? H_BITS'(MAX_HEIGHT) :
                     H_BITS'(i_cfg_data);

    assign w_col_ext  = W_BITS'(r_col);
    assign w_col_inc  = w_col_ext + W_BITS'(1);
    assign w_h_ext    = ROW_BITS'(r_h);
    assign w_h_p1     = w_h_ext + ROW_BITS'(1);
    assign w_row_ge_h = (r_row >= w_h_ext);
    assign w_ignore   = (i_item.action || w_row_ge_h) && !w_row_ge_h;
    assign w_abort    = (w_col_ext >= r_w) || (r_row > w_h_p1);
    assign w_first    = (r_col == '0);
    assign w_edge     = w_first && (r_row >= ROW_BITS'(2));
    assign w_col_step = (r_row <= w_h_ext);
    assign w_last     = w_edge && (r_row == w_h_p1);

    always_comb begin
        o_op.kind      = w_abort ? OP_CLEAR : OP_COLUMN;
        o_op.first_col = w_first;
        o_op.edge_emit = w_edge;
        o_op.col_step  = w_col_step;
        o_op.top_en    = (r_row >= ROW_BITS'(2));
        o_op.mid_en    = (r_row >= ROW_BITS'(1));
        o_op.wr_en     = (r_row < w_h_ext);
        o_op.col_emit  = !w_first && (r_row >= ROW_BITS'(1)) && w_col_step;
        o_op.last      = w_last;
        o_op.pixel     = i_item.pixel;
        o_addr         = r_col;
        o_push         = i_accept && !w_ignore && (w_abort || w_first || w_col_step);
    end

    always_comb begin
        n_w   = r_w;
        n_h   = r_h;
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  n_w = w_cfg_w;
                CFG_IMAGE_HEIGHT: n_h = w_cfg_h;
                default: ;
            endcase
            n_col = '0;
            n_row = '0;
        end else if (i_accept && !w_ignore) begin
            if (w_abort || w_last) begin
                n_col = '0;
                n_row = '0;
            end else if (w_col_inc >= r_w) begin
                n_col = '0;
                n_row = r_row + ROW_BITS'(1);
            end else begin
                n_col = COL_BITS'(w_col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w   <= RST_W;
            r_h   <= RST_H;
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_w   <= n_w;
            r_h   <= n_h;
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

@@ rtl/ghp_queue.sv @@
module ghp_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    import ghp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/ghp_back.sv @@
module ghp_back #(
    parameter int MAX_WIDTH = ghp_pkg::DEF_MAX_WIDTH,
    parameter int COL_BITS  = $clog2(MAX_WIDTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic                i_head_valid,
    input  ghp_pkg::t_op        i_head_op,
    input  logic [COL_BITS-1:0] i_head_addr,
    output logic                o_pop,
    output logic                o_out_valid,
    output ghp_pkg::t_out_item  o_out_item,
    input  logic                i_out_stall
);
    import ghp_pkg::*;

    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

    function automatic t_win shift_col(t_win w, logic [PIX_W-1:0] top,
                                       logic [PIX_W-1:0] mid, logic [PIX_W-1:0] bot);
        t_win r;
        r = w;
        for (int i = 0; i < 3; i++) begin
            r[i][0] = w[i][1];
            r[i][1] = w[i][2];
        end
        r[0][2] = top;
        r[1][2] = mid;
        r[2][2] = bot;
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] high_pass(t_win w);
        logic [11:0] s;
        s = 12'(w[0][0]) + {3'd0, w[0][1], 1'b0} + 12'(w[0][2])
          + {3'd0, w[1][0], 1'b0} + {2'd0, w[1][1], 2'b0} + {3'd0, w[1][2], 1'b0}
          + 12'(w[2][0]) + {3'd0, w[2][1], 1'b0} + 12'(w[2][2]);
        return w[1][1] - s[11:4];
    endfunction

    logic [PIX_W-1:0]    r_upper  [MAX_WIDTH];
    logic [PIX_W-1:0]    r_middle [MAX_WIDTH];
    logic [PIX_W-1:0]    r_rd_up, r_rd_mid;
    logic                r_fwd;
    logic [PIX_W-1:0]    r_fwd_up, r_fwd_mid;
    logic                r_s1_valid;
    t_op                 r_s1_op;
    logic [COL_BITS-1:0] r_s1_addr;
    t_win                r_win, n_win;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic                w_adv;
    logic                w_s1_col;
    logic                w_s1_wr;
    logic [PIX_W-1:0]    w_s1_up, w_s1_mid;
    logic [PIX_W-1:0]    w_top, w_mid, w_bot;
    t_win                w_win_a, w_win_b, w_win_sel;
    logic                w_emit;

    assign w_adv     = !r_out_valid || !i_out_stall;
    assign o_pop     = w_adv && i_head_valid;
    assign w_s1_col  = r_s1_valid && (r_s1_op.kind == OP_COLUMN);
    assign w_s1_wr   = w_adv && w_s1_col && r_s1_op.wr_en;
    assign w_s1_up   = r_fwd ? r_fwd_up : r_rd_up;
    assign w_s1_mid  = r_fwd ? r_fwd_mid : r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (w_s1_wr) begin
            r_upper[r_s1_addr]  <= w_s1_mid;
            r_middle[r_s1_addr] <= r_s1_op.pixel;
        end
        if (o_pop) begin
            r_rd_up  <= r_upper[i_head_addr];
            r_rd_mid <= r_middle[i_head_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_op   <= i_head_op;
            r_s1_addr <= i_head_addr;
            r_fwd     <= w_s1_wr && (i_head_addr == r_s1_addr);
            r_fwd_up  <= w_s1_mid;
            r_fwd_mid <= r_s1_op.pixel;
        end
    end

    always_comb begin
        w_top     = r_s1_op.top_en ? w_s1_up : '0;
        w_mid     = r_s1_op.mid_en ? w_s1_mid : '0;
        w_bot     = r_s1_op.wr_en ? r_s1_op.pixel : '0;
        w_win_a   = r_s1_op.first_col ? shift_col(r_win, '0, '0, '0) : r_win;
        w_win_b   = r_s1_op.col_step ? shift_col(w_win_a, w_top, w_mid, w_bot) : w_win_a;
        w_win_sel = r_s1_op.edge_emit ? w_win_a : w_win_b;
        w_emit    = r_s1_op.edge_emit || r_s1_op.col_emit;
        n_win     = r_win;
        if (i_clear) begin
            n_win = '0;
        end else if (w_adv && r_s1_valid) begin
            if (!w_s1_col || r_s1_op.last) begin
                n_win = '0;
            end else begin
                n_win = w_win_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_item.result_pixel  <= high_pass(w_win_sel);
            r_out_item.last_of_frame <= r_s1_op.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_win       <= '0;
        end else begin
            r_win <= n_win;
            if (w_adv) begin
                r_s1_valid  <= i_head_valid;
                r_out_valid <= w_s1_col && w_emit;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ dv/tb_gaussian_highpass_3x3.sv @@
`timescale 1ns / 1ps
module tb_gaussian_highpass_3x3;
    import ghp_pkg::*;

    localparam logic ACT_PIXEL          = 1'b0;
    localparam logic ACT_DRAIN          = 1'b1;
    localparam int   DRAIN_PAD          = 8;
    localparam int   CYCLE_LIMIT        = 400_000;
    localparam int   RANDOM_PHASE_ITEMS = 50;
    localparam int   HOLD_OFF_CYCLES    = 300;
    localparam int   MAX_REPORTS        = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    t_in_item             in_item;
    logic                 out_valid;
    logic                 out_stall;
    t_out_item            out_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    logic [PIX_W-1:0] row_upper  [DEF_MAX_WIDTH];
    logic [PIX_W-1:0] row_middle [DEF_MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      out_cnt;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    t_out_item        highpass_q[$];

    int errors         = 0;
    int sent_cnt       = 0;
    int hold_left      = 0;
    int cycle_cnt      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    gaussian_highpass_3x3 u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return 32'(v);
    endfunction

    function automatic void restart_frame();
        col_pos = 0;
        row_pos = 0;
        out_cnt = 0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) win[r][c] = '0;
        end
    endfunction

    function automatic void shift_column(input logic [PIX_W-1:0] top, input logic [PIX_W-1:0] mid,
                                         input logic [PIX_W-1:0] bot);
        logic [PIX_W-1:0] col [3];
        col[0] = top;
        col[1] = mid;
        col[2] = bot;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
            win[r][2] = col[r];
        end
    endfunction

    function automatic logic [PIX_W-1:0] window_highpass();
        int unsigned s;
        s = int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2])
          + 2 * int'(win[1][0]) + 4 * int'(win[1][1]) + 2 * int'(win[1][2])
          + int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]);
        return PIX_W'(int'(win[1][1]) - int'(s >> 4));
    endfunction

    function automatic void predict_highpass(input t_in_item it);
        int unsigned      w;
        int unsigned      h;
        int unsigned      ic;
        int unsigned      ir;
        logic             drain;
        logic             emit;
        logic [PIX_W-1:0] val;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
        t_out_item        res;
        w     = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h     = clamp_dim(height_reg, DEF_MAX_HEIGHT);
        drain = (it.action == ACT_DRAIN) || (row_pos >= h);
        ic    = col_pos;
        ir    = row_pos;
        emit  = 1'b0;
        val   = '0;
        if (drain && ir < h) return;
        if (ic >= w || ir > h + 1) begin
            restart_frame();
            return;
        end
        if (ic == 0) begin
            shift_column('0, '0, '0);
            if (ir >= 2) begin
                emit = 1'b1;
                val  = window_highpass();
            end
        end
        if (ir <= h) begin
            top = (ir >= 2) ? row_upper[ic] : '0;
            mid = (ir >= 1) ? row_middle[ic] : '0;
            bot = (ir < h) ? it.pixel : '0;
            if (ir < h) begin
                row_upper[ic]  = row_middle[ic];
                row_middle[ic] = it.pixel;
            end
            shift_column(top, mid, bot);
            if (ic >= 1 && ir >= 1) begin
                emit = 1'b1;
                val  = window_highpass();
            end
        end
        col_pos = ic + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = ir + 1;
        end
        if (!emit) return;
        out_cnt++;
        res.result_pixel  = val;
        res.last_of_frame = (out_cnt >= w * h);
        highpass_q.push_back(res);
        if (res.last_of_frame || row_pos > h + 1) restart_frame();
    endfunction

    function automatic t_in_item mk_item(input logic act, input logic [PIX_W-1:0] pix);
        t_in_item it;
        it.action = act;
        it.pixel  = pix;
        return it;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
        return PIX_W'($urandom);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(input int unsigned maxd, input int unsigned wide);
        case ($urandom_range(15))
            0: return '0;
            1: return DIM_W'($urandom_range(maxd + 1, wide));
            default: return DIM_W'($urandom_range(1, maxd));
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_highpass(it);
        sent_cnt++;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained(input int pad);
        in_valid <= 1'b0;
        while (highpass_q.size() != 0) @(posedge clk);
        repeat (pad) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_IMAGE_WIDTH) width_reg = data;
        else if (idx == CFG_IMAGE_HEIGHT) height_reg = data;
        restart_frame();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_drained(DRAIN_PAD);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic send_frame(input bit noisy, input int pause_at);
        int unsigned w;
        int unsigned h;
        w = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
        for (int p = 0; p < int'(w * h); p++) begin
            if (p == pause_at) wait_drained(1);
            if (noisy && $urandom_range(19) == 0) send_item(mk_item(ACT_DRAIN, rand_pixel()));
            send_item(mk_item(ACT_PIXEL, rand_pixel()));
        end
        for (int d = 0; d <= int'(w); d++) begin
            if (noisy && $urandom_range(4) == 0) send_item(mk_item(ACT_PIXEL, rand_pixel()));
            else send_item(mk_item(ACT_DRAIN, rand_pixel()));
        end
    endtask

    task automatic test_reset_defaults();
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        for (int i = 0; i < DEF_MAX_WIDTH + 4; i++) send_item(mk_item(ACT_PIXEL, rand_pixel()));
        wait_drained(DRAIN_PAD);
    endtask

    task automatic test_directed_patterns();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(DIM_W'(3), DIM_W'(3));
        for (int i = 0; i < 9; i++) begin
            send_item(mk_item(ACT_PIXEL, (i % 2 == 0) ? 8'hFF : 8'h00));
            if (i == 3) send_item(mk_item(ACT_DRAIN, 8'hFF));
        end
        send_item(mk_item(ACT_DRAIN, 8'h00));
        send_item(mk_item(ACT_DRAIN, 8'hFF));
        send_item(mk_item(ACT_PIXEL, 8'h5A));
        send_item(mk_item(ACT_DRAIN, 8'hA5));
        send_item(mk_item(ACT_DRAIN, 8'h00));
        configure(DIM_W'(2), DIM_W'(2));
        for (int i = 0; i < 4; i++) send_item(mk_item(ACT_PIXEL, 8'hFF));
        for (int i = 0; i < 3; i++) send_item(mk_item(ACT_DRAIN, 8'h00));
        wait_drained(DRAIN_PAD);
    endtask

    task automatic test_dimension_extremes();
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        configure('0, '0);
        send_frame(1'b0, -1);
        configure(DIM_W'(1), DIM_W'(1023));
        send_frame(1'b0, -1);
        wait_drained(DRAIN_PAD);
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(DIM_W'(8), DIM_W'(6));
        hold_left = HOLD_OFF_CYCLES;
        send_frame(1'b0, 30);
        wait_drained(DRAIN_PAD);
    endtask

    task automatic test_random_frames();
        int          start;
        int          kind;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            start = sent_cnt;
            kind  = 0;
            while (sent_cnt - start < RANDOM_PHASE_ITEMS) begin
                if (kind <= 1) configure(pick_dim(12, 40), pick_dim(8, 16));
                kind = $urandom_range(9);
                if (kind == 8) begin
                    w = clamp_dim(width_reg, DEF_MAX_WIDTH);
                    h = clamp_dim(height_reg, DEF_MAX_HEIGHT);
                    n = (w * h > 1) ? $urandom_range(w * h - 1) : 0;
                    for (int unsigned i = 0; i < n; i++) begin
                        send_item(mk_item(ACT_PIXEL, rand_pixel()));
                    end
                    wait_drained(DRAIN_PAD);
                    if ($urandom_range(1)) begin
                        write_reg(CFG_IDX_W'($urandom_range(2, 255)), DIM_W'($urandom));
                    end else begin
                        write_reg(CFG_IMAGE_HEIGHT, height_reg);
                    end
                end else if (kind == 9) begin
                    repeat ($urandom_range(1, 3)) send_item(mk_item(ACT_DRAIN, rand_pixel()));
                end else begin
                    send_frame(1'b1, -1);
                end
            end
        end
        wait_drained(DRAIN_PAD);
    endtask

    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
        if (rst_n && out_valid && !out_stall) begin
            if (highpass_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected result: pixel %0d last %0b",
                             out_item.result_pixel, out_item.last_of_frame);
                end
            end else begin
                if (out_item.result_pixel !== highpass_q[0].result_pixel ||
                    out_item.last_of_frame !== highpass_q[0].last_of_frame) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                                 highpass_q[0].result_pixel, highpass_q[0].last_of_frame,
                                 out_item.result_pixel, out_item.last_of_frame);
                    end
                end
                void'(highpass_q.pop_front());
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        width_reg  = DIM_W'(CFG_RESET_DIM);
        height_reg = DIM_W'(CFG_RESET_DIM);
        for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
            row_upper[i]  = '0;
            row_middle[i] = '0;
        end
        restart_frame();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_patterns();
        test_dimension_extremes();
        test_backpressure();
        test_random_frames();

        wait_drained(DRAIN_PAD);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
